[rtl/smts_pkg.sv]
// ----------------------------------------------------------------------------
// smts_pkg: shared types, constants and helpers
// Number format, CORDIC arctangent table, item and result records, rounding
// and saturation used by the sensor-measurement-to-state pipeline.
// ----------------------------------------------------------------------------
package smts_pkg;

	// Field width; every field is two's complement with 16 fraction bits.
	localparam int DATA_WIDTH = 32;
	// One micro-rotation per stage.
	localparam int CORDIC_STAGES = 16;
	// Extra fraction bits carried by the CORDIC x/y datapath.
	localparam int GUARD = 61 - DATA_WIDTH;
	// Width of the CORDIC x/y datapath.
	localparam int XW = 64;
	// Width of the gain constant and of one multiplier operand.
	localparam int KW = 32;
	// Angle accumulator: holds a folded bearing plus the table sum.
	localparam int ZW = ((DATA_WIDTH > 20) ? DATA_WIDTH : 20) + 2;

	// CORDIC gain correction, 0.60725293... in 0.32 format.
	localparam logic [KW-1:0] GAIN_K = 32'h9B74EDA8;

	localparam logic signed [ZW-1:0] PI_Q      = ZW'(205887);
	localparam logic signed [ZW-1:0] HALF_PI_Q = ZW'(102944);

	localparam logic signed [XW-1:0] FMAX_X =
		{{(XW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
	localparam logic signed [XW-1:0] FMIN_X =
		{{(XW-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}};
	localparam logic signed [ZW-1:0] FMAX_Z =
		{{(ZW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
	localparam logic signed [ZW-1:0] FMIN_Z =
		{{(ZW-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}};

	typedef enum logic [1:0] {
		KIND_LIDAR = 2'd0,
		KIND_RADAR = 2'd1,
		KIND_FULL  = 2'd2,
		KIND_TRUTH = 2'd3
	} kind_t;

	// One measurement on its way through the pipeline.
	typedef struct packed {
		kind_t                 kind;
		logic                  flip;  // negate x after the gain multiply
		logic                  zero;  // truth item with zero velocity
		logic [XW-1:0]         x;
		logic [XW-1:0]         y;
		logic [ZW-1:0]         z;
		logic [DATA_WIDTH-1:0] a;
		logic [DATA_WIDTH-1:0] b;
		logic [DATA_WIDTH-1:0] c;
		logic [DATA_WIDTH-1:0] d;
		logic [DATA_WIDTH-1:0] e;
	} item_t;

	typedef struct packed {
		logic [DATA_WIDTH-1:0] pos_x;
		logic [DATA_WIDTH-1:0] pos_y;
		logic [DATA_WIDTH-1:0] speed;
		logic [DATA_WIDTH-1:0] heading;
		logic [DATA_WIDTH-1:0] yaw_rate;
	} result_t;

	// round(atan(2^-i) * 2^16); zero from i = 17 on.
	function automatic logic [15:0] atan_q(input int i);
		case (i)
			0:       return 16'd51472;
			1:       return 16'd30386;
			2:       return 16'd16055;
			3:       return 16'd8150;
			4:       return 16'd4091;
			5:       return 16'd2047;
			6:       return 16'd1024;
			7:       return 16'd512;
			8:       return 16'd256;
			9:       return 16'd128;
			10:      return 16'd64;
			11:      return 16'd32;
			12:      return 16'd16;
			13:      return 16'd8;
			14:      return 16'd4;
			15:      return 16'd2;
			16:      return 16'd1;
			default: return 16'd0;
		endcase
	endfunction

	function automatic logic [DATA_WIDTH-1:0] sat_x(input logic signed [XW-1:0] r);
		if (r > FMAX_X)
			return FMAX_X[DATA_WIDTH-1:0];
		else if (r < FMIN_X)
			return FMIN_X[DATA_WIDTH-1:0];
		else
			return r[DATA_WIDTH-1:0];
	endfunction

	function automatic logic [DATA_WIDTH-1:0] sat_z(input logic signed [ZW-1:0] r);
		if (r > FMAX_Z)
			return FMAX_Z[DATA_WIDTH-1:0];
		else if (r < FMIN_Z)
			return FMIN_Z[DATA_WIDTH-1:0];
		else
			return r[DATA_WIDTH-1:0];
	endfunction

	// Round half up from GUARD extra fraction bits, then saturate.
	function automatic logic [DATA_WIDTH-1:0] round_out(input logic [XW-1:0] v);
		logic [XW-1:0]        t;
		logic signed [XW-1:0] r;
		t = v + (XW'(1) << (GUARD - 1));
		r = $signed(t) >>> GUARD;
		return sat_x(r);
	endfunction

endpackage

[rtl/sensor_measurement_to_state_core.sv]
// ----------------------------------------------------------------------------
// sensor_measurement_to_state_core: measurement to tracking state
// Turns one tagged lidar, radar, full-state or ground-truth measurement into
// position, speed, heading and yaw rate, with CORDIC for polar conversion.
// ----------------------------------------------------------------------------
//
//  channel  | handshake              | payload
//  ---------+------------------------+----------------------------------------
//  input    | in_valid / in_ready    | sensor_kind, meas_a .. meas_e
//  output   | out_valid / out_ready  | pos_x, pos_y, speed, heading, yaw_rate
//
// One item enters per cycle while the pipeline is not stalled. The stages in
// order: decode, pre-gain multiply, CORDIC micro-rotations one per stage,
// post-gain multiply, round/select, output register.
// All stages advance together on one enable, which drops only when the
// single skid entry behind the output register is full; in_ready follows
// that enable, so it comes straight from a flop.
// Reset clears every valid bit, also those of the output buffer; data flops are not reset.
//
// Radar: x = K * range, CORDIC rotation by the folded bearing, x negated
// when the bearing was folded by pi. Truth: CORDIC vectoring on the velocity,
// then speed = K * x; heading is the angle accumulator.
// ----------------------------------------------------------------------------
module sensor_measurement_to_state_core import smts_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   sensor_kind,
	input  logic signed [DATA_WIDTH-1:0] meas_a,
	input  logic signed [DATA_WIDTH-1:0] meas_b,
	input  logic signed [DATA_WIDTH-1:0] meas_c,
	input  logic signed [DATA_WIDTH-1:0] meas_d,
	input  logic signed [DATA_WIDTH-1:0] meas_e,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [DATA_WIDTH-1:0] pos_x,
	output logic signed [DATA_WIDTH-1:0] pos_y,
	output logic signed [DATA_WIDTH-1:0] speed,
	output logic signed [DATA_WIDTH-1:0] heading,
	output logic signed [DATA_WIDTH-1:0] yaw_rate
);

	logic    adv;
	logic    prep_v, pre_v, cor_v, post_v;
	item_t   prep_item, pre_item, cor_item, post_item;
	result_t res;

	// whole pipeline moves on adv; an item is taken whenever it moves
	assign in_ready = adv;

	smts_prep u_prep (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.in_valid   (in_valid),
		.sensor_kind(sensor_kind),
		.meas_a     (meas_a),
		.meas_b     (meas_b),
		.meas_c     (meas_c),
		.meas_d     (meas_d),
		.meas_e     (meas_e),
		.out_valid  (prep_v),
		.out_item   (prep_item)
	);

	// radar: scale the range by K before rotating, apply the fold sign
	smts_gain u_pre_gain (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (prep_v),
		.in_item  (prep_item),
		.gain_en  (prep_item.kind == KIND_RADAR),
		.out_valid(pre_v),
		.out_item (pre_item)
	);

	smts_cordic u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (pre_v),
		.in_item  (pre_item),
		.out_valid(cor_v),
		.out_item (cor_item)
	);

	// truth: scale the vectored magnitude by K
	smts_gain u_post_gain (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (cor_v),
		.in_item  (cor_item),
		.gain_en  (cor_item.kind == KIND_TRUTH),
		.out_valid(post_v),
		.out_item (post_item)
	);

	smts_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (post_v),
		.in_item  (post_item),
		.adv      (adv),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_res  (res)
	);

	assign pos_x    = res.pos_x;
	assign pos_y    = res.pos_y;
	assign speed    = res.speed;
	assign heading  = res.heading;
	assign yaw_rate = res.yaw_rate;

	// a stalled pipeline means the output register holds an item
	a_stall_has_output: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |-> out_valid)
		else $error("pipeline stalled with empty output register");

	// the pipeline only stops after the output was refused
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(adv) |-> $past(out_valid && !out_ready))
		else $error("pipeline stalled without back-pressure");

	// the fold sign is consumed by the pre-gain stage
	a_flip_consumed: assert property (@(posedge clk) disable iff (!arst_n)
		pre_v |-> !pre_item.flip)
		else $error("fold sign left pending after gain stage");

	// vectoring never drives the magnitude negative
	a_truth_mag_pos: assert property (@(posedge clk) disable iff (!arst_n)
		post_v && (post_item.kind == KIND_TRUTH) |-> !post_item.x[XW-1])
		else $error("negative magnitude on truth item");

endmodule

[rtl/smts_prep.sv]
// ----------------------------------------------------------------------------
// smts_prep: measurement decode stage
// Sets up the CORDIC operands: quadrant fold for radar bearings, half-plane
// fold and zero detect for truth velocities.
// ----------------------------------------------------------------------------
module smts_prep import smts_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         adv,
	input  logic                         in_valid,
	input  logic [1:0]                   sensor_kind,
	input  logic signed [DATA_WIDTH-1:0] meas_a,
	input  logic signed [DATA_WIDTH-1:0] meas_b,
	input  logic signed [DATA_WIDTH-1:0] meas_c,
	input  logic signed [DATA_WIDTH-1:0] meas_d,
	input  logic signed [DATA_WIDTH-1:0] meas_e,
	output logic                         out_valid,
	output item_t                        out_item
);

	logic  valid_s1;
	item_t item_s1;
	item_t nxt;

	logic signed [ZW-1:0] phi;
	logic [XW-1:0]        rho_x;
	logic [XW-1:0]        vx_x;
	logic [XW-1:0]        vy_x;

	always_comb begin
		phi   = ZW'(meas_b);
		rho_x = XW'(meas_a) << GUARD;
		vx_x  = XW'(meas_c) << GUARD;
		vy_x  = XW'(meas_d) << GUARD;

		nxt      = '0;
		nxt.kind = kind_t'(sensor_kind);
		nxt.a    = meas_a;
		nxt.b    = meas_b;
		nxt.c    = meas_c;
		nxt.d    = meas_d;
		nxt.e    = meas_e;
		nxt.zero = (meas_c == '0) && (meas_d == '0);

		case (kind_t'(sensor_kind))
			KIND_RADAR: begin
				// fold the bearing into plus minus pi/2, negate x later
				nxt.x = rho_x;
				if (phi > HALF_PI_Q) begin
					nxt.z    = phi - PI_Q;
					nxt.flip = 1'b1;
				end else if (phi < -HALF_PI_Q) begin
					nxt.z    = phi + PI_Q;
					nxt.flip = 1'b1;
				end else begin
					nxt.z = phi;
				end
			end
			KIND_TRUTH: begin
				// left half-plane: rotate by pi first
				if (meas_c[DATA_WIDTH-1]) begin
					nxt.x = -vx_x;
					nxt.y = -vy_x;
					nxt.z = meas_d[DATA_WIDTH-1] ? -PI_Q : PI_Q;
				end else begin
					nxt.x = vx_x;
					nxt.y = vy_x;
				end
			end
			default: begin
				nxt.x = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (adv)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (adv)
			item_s1 <= nxt;
	end

	assign out_valid = valid_s1;
	assign out_item  = item_s1;

endmodule

[rtl/smts_gain.sv]
// ----------------------------------------------------------------------------
// smts_gain: CORDIC gain correction
// Four stages: magnitude, two 32x32 partial products, sum, sign restore.
// Items without gain_en pass through unchanged.
// ----------------------------------------------------------------------------
module smts_gain import smts_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  adv,
	input  logic  in_valid,
	input  item_t in_item,
	input  logic  gain_en,
	output logic  out_valid,
	output item_t out_item
);

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic en_s1, en_s2, en_s3;
	logic neg_s1, neg_s2, neg_s3;
	item_t item_s1, item_s2, item_s3, item_s4;
	logic [XW-1:0] mag_s1;
	logic [XW-1:0] pph_s2;
	logic [KW-1:0] ppl_s2;
	logic [XW-1:0] sum_s3;

	logic          x_neg;
	logic [XW-1:0] lo_prod;
	item_t         fin;

	assign x_neg   = in_item.x[XW-1];
	assign lo_prod = XW'(mag_s1[KW-1:0]) * XW'(GAIN_K);

	always_comb begin
		fin = item_s3;
		if (en_s3) begin
			fin.x    = neg_s3 ? -sum_s3 : sum_s3;
			fin.flip = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// stage 1: magnitude, final sign
			item_s1 <= in_item;
			en_s1   <= gain_en;
			neg_s1  <= x_neg ^ in_item.flip;
			mag_s1  <= x_neg ? -in_item.x : in_item.x;
			// stage 2: partial products, keep top half of the low one
			item_s2 <= item_s1;
			en_s2   <= en_s1;
			neg_s2  <= neg_s1;
			pph_s2  <= XW'(mag_s1[XW-1:KW]) * XW'(GAIN_K);
			ppl_s2  <= lo_prod[XW-1:KW];
			// stage 3: sum
			item_s3 <= item_s2;
			en_s3   <= en_s2;
			neg_s3  <= neg_s2;
			sum_s3  <= pph_s2 + XW'(ppl_s2);
			// stage 4: restore sign
			item_s4 <= fin;
		end
	end

	assign out_valid = valid_s4;
	assign out_item  = item_s4;

endmodule

[rtl/smts_cordic.sv]
// ----------------------------------------------------------------------------
// smts_cordic: unrolled CORDIC pipeline
// One micro-rotation per stage. Truth items steer by the sign of y
// (vectoring), all others by the sign of z (rotation).
// ----------------------------------------------------------------------------
module smts_cordic import smts_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  adv,
	input  logic  in_valid,
	input  item_t in_item,
	output logic  out_valid,
	output item_t out_item
);

	logic  valid_s [CORDIC_STAGES];
	item_t item_s  [CORDIC_STAGES];

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
		localparam logic [ZW-1:0] ATAN_I = ZW'(atan_q(i));

		item_t         cur;
		item_t         nxt;
		logic          cur_v;
		logic [XW-1:0] xs;
		logic [XW-1:0] ys;
		logic          up;

		if (i == 0) begin : g_first
			assign cur   = in_item;
			assign cur_v = in_valid;
		end else begin : g_next
			assign cur   = item_s[i-1];
			assign cur_v = valid_s[i-1];
		end

		always_comb begin
			xs  = $signed(cur.x) >>> i;
			ys  = $signed(cur.y) >>> i;
			up  = (cur.kind == KIND_TRUTH) ? !cur.y[XW-1] : cur.z[ZW-1];
			nxt = cur;
			if (up) begin
				nxt.x = cur.x + ys;
				nxt.y = cur.y - xs;
				nxt.z = cur.z + ATAN_I;
			end else begin
				nxt.x = cur.x - ys;
				nxt.y = cur.y + xs;
				nxt.z = cur.z - ATAN_I;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				valid_s[i] <= 1'b0;
			else if (adv)
				valid_s[i] <= cur_v;
		end

		always_ff @(posedge clk) begin
			if (adv)
				item_s[i] <= nxt;
		end
	end

	assign out_valid = valid_s[CORDIC_STAGES-1];
	assign out_item  = item_s[CORDIC_STAGES-1];

endmodule

[rtl/smts_out.sv]
// ----------------------------------------------------------------------------
// smts_out: result stage and output buffer
// Round, saturate and select the five fields per kind, then hold results in
// an output register backed by one skid entry.
// ----------------------------------------------------------------------------
module smts_out import smts_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  item_t   in_item,
	output logic    adv,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_res
);

	logic    valid_s1;
	result_t res_s1;
	result_t res;
	logic    out_v_q;
	result_t out_q;
	logic    skid_v_q;
	result_t skid_q;

	logic [DATA_WIDTH-1:0] rx;
	logic [DATA_WIDTH-1:0] ry;
	logic [DATA_WIDTH-1:0] hd;
	logic                  take;

	assign adv  = !skid_v_q;
	assign take = adv && valid_s1;

	always_comb begin
		rx  = round_out(in_item.x);
		ry  = round_out(in_item.y);
		hd  = sat_z($signed(in_item.z));
		res = '0;
		res.pos_x = in_item.a;
		res.pos_y = in_item.b;
		case (in_item.kind)
			KIND_RADAR: begin
				res.pos_x = rx;
				res.pos_y = ry;
			end
			KIND_FULL: begin
				res.speed    = in_item.c;
				res.heading  = in_item.d;
				res.yaw_rate = in_item.e;
			end
			KIND_TRUTH: begin
				// zero velocity: no direction, speed and heading stay zero
				if (!in_item.zero) begin
					res.speed   = rx;
					res.heading = hd;
				end
			end
			default: begin
				res.speed = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (adv)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (adv)
			res_s1 <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || out_ready) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= take;
			end
		end else if (take) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || out_ready) begin
			if (skid_v_q)
				out_q <= skid_q;
			else if (take)
				out_q <= res_s1;
		end else if (take) begin
			skid_q <= res_s1;
		end
	end

	assign out_valid = out_v_q;
	assign out_res   = out_q;

endmodule
